/* src/asn1_time_to_epoch_seconds_top_defines.svh */
// assertion macros for the time string decoder
`ifndef ASN1_TIME_TO_EPOCH_SECONDS_TOP_DEFINES_SVH
`define ASN1_TIME_TO_EPOCH_SECONDS_TOP_DEFINES_SVH

// same-cycle implication
`define A1T_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define A1T_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* src/asn1t_pkg.sv */
// types, constants and microcode for the time string decoder
`default_nettype none
package asn1t_pkg;

  localparam int SEC_W       = 39;
  localparam int STORE_DEPTH = 15;
  localparam int PC_W        = 5;

  localparam logic [7:0] ASCII_ZERO = 8'h30;
  localparam logic [7:0] ASCII_NINE = 8'h39;
  localparam logic [4:0] COUNT_MAX  = 5'd31;
  localparam logic [4:0] MIN_LEN    = 5'd13;
  localparam logic [4:0] GEN_LEN    = 5'd15;
  localparam logic [4:0] POS_YEAR_LO = 5'd4;
  localparam logic [6:0] YY_PIVOT   = 7'd50;
  localparam logic [6:0] CENT_20    = 7'd20;
  localparam logic [6:0] CENT_19    = 7'd19;
  localparam logic [3:0] BASE_GEN   = 4'd4;
  localparam logic [3:0] BASE_UTC   = 4'd2;
  localparam logic [SEC_W-1:0] EPOCH_YEAR = 39'd1970;
  localparam logic [SEC_W-1:0] LEAP_BASE  = 39'd574;
  localparam logic [SEC_W-1:0] DAYS_YEAR  = 39'd365;
  localparam logic [SEC_W-1:0] SECS_DAY   = 39'd86400;
  localparam logic [PC_W-1:0]  PC_FIN     = 5'd25;

  typedef enum logic [4:0] {
    OP_NOP, OP_HI, OP_LO_C, OP_LO_YY, OP_LO_MON, OP_LO_DAY, OP_LO_HOUR,
    OP_LO_MIN, OP_LO_SEC, OP_CENT, OP_YEAR, OP_MUL365, OP_LEAP, OP_MONTH,
    OP_MULDAY, OP_HMS, OP_FIN
  } op_t;

  typedef enum logic [1:0] {
    COND_NONE, COND_SHORT, COND_UTC, COND_ALWAYS
  } cond_t;

  typedef struct packed {
    op_t             op;
    logic            rd_rel;
    logic [3:0]      rd_off;
    cond_t           cond;
    logic [PC_W-1:0] target;
  } ctrl_t;

  function automatic ctrl_t ucode_rom(input logic [PC_W-1:0] pc);
    ctrl_t cw;
    cw = '{OP_NOP, 1'b0, 4'd0, COND_NONE, 5'd0};
    case (pc)
      5'd0:  cw = '{OP_NOP,     1'b0, 4'd0, COND_SHORT,  PC_FIN};
      5'd1:  cw = '{OP_NOP,     1'b0, 4'd0, COND_UTC,    5'd6};
      5'd2:  cw = '{OP_HI,      1'b0, 4'd1, COND_NONE,   5'd0};
      5'd3:  cw = '{OP_LO_C,    1'b0, 4'd2, COND_NONE,   5'd0};
      5'd4:  cw = '{OP_HI,      1'b0, 4'd3, COND_NONE,   5'd0};
      5'd5:  cw = '{OP_LO_YY,   1'b1, 4'd0, COND_ALWAYS, 5'd9};
      5'd6:  cw = '{OP_HI,      1'b0, 4'd1, COND_NONE,   5'd0};
      5'd7:  cw = '{OP_LO_YY,   1'b1, 4'd0, COND_NONE,   5'd0};
      5'd8:  cw = '{OP_CENT,    1'b1, 4'd0, COND_NONE,   5'd0};
      5'd9:  cw = '{OP_HI,      1'b1, 4'd1, COND_NONE,   5'd0};
      5'd10: cw = '{OP_LO_MON,  1'b1, 4'd2, COND_NONE,   5'd0};
      5'd11: cw = '{OP_HI,      1'b1, 4'd3, COND_NONE,   5'd0};
      5'd12: cw = '{OP_LO_DAY,  1'b1, 4'd4, COND_NONE,   5'd0};
      5'd13: cw = '{OP_HI,      1'b1, 4'd5, COND_NONE,   5'd0};
      5'd14: cw = '{OP_LO_HOUR, 1'b1, 4'd6, COND_NONE,   5'd0};
      5'd15: cw = '{OP_HI,      1'b1, 4'd7, COND_NONE,   5'd0};
      5'd16: cw = '{OP_LO_MIN,  1'b1, 4'd8, COND_NONE,   5'd0};
      5'd17: cw = '{OP_HI,      1'b1, 4'd9, COND_NONE,   5'd0};
      5'd18: cw = '{OP_LO_SEC,  1'b0, 4'd0, COND_NONE,   5'd0};
      5'd19: cw = '{OP_YEAR,    1'b0, 4'd0, COND_NONE,   5'd0};
      5'd20: cw = '{OP_MUL365,  1'b0, 4'd0, COND_NONE,   5'd0};
      5'd21: cw = '{OP_LEAP,    1'b0, 4'd0, COND_NONE,   5'd0};
      5'd22: cw = '{OP_MONTH,   1'b0, 4'd0, COND_NONE,   5'd0};
      5'd23: cw = '{OP_MULDAY,  1'b0, 4'd0, COND_NONE,   5'd0};
      5'd24: cw = '{OP_HMS,     1'b0, 4'd0, COND_NONE,   5'd0};
      5'd25: cw = '{OP_FIN,     1'b0, 4'd0, COND_NONE,   5'd0};
      default: cw = '{OP_NOP,   1'b0, 4'd0, COND_NONE,   5'd0};
    endcase
    return cw;
  endfunction

  // days before the first of each month, non-leap year
  function automatic logic [8:0] month_offset(input logic [6:0] mon);
    logic [8:0] d;
    d = 9'd0;
    case (mon)
      7'd1:  d = 9'd0;
      7'd2:  d = 9'd31;
      7'd3:  d = 9'd59;
      7'd4:  d = 9'd90;
      7'd5:  d = 9'd120;
      7'd6:  d = 9'd151;
      7'd7:  d = 9'd181;
      7'd8:  d = 9'd212;
      7'd9:  d = 9'd243;
      7'd10: d = 9'd273;
      7'd11: d = 9'd304;
      7'd12: d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage
`default_nettype wire

/* src/asn1_time_to_epoch_seconds_top.sv */
// time string decoder: character store, microcoded date sequencer, result register
// characters are taken one per cycle while busy is low; the last one starts the sequencer
// after the last character the sequencer reads a four-digit year, or a two-digit year with
// a pivot century; a string shorter than thirteen characters goes straight to the finish step
// one microcode step per cycle, with one store read per step
// synchronous active-high reset clears the count, the sequencer and done; store is not cleared
`default_nettype none
`include "asn1_time_to_epoch_seconds_top_defines.svh"
module asn1_time_to_epoch_seconds_top (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               start,
  input  wire logic [7:0]                         character,
  input  wire logic                               last_char,
  output logic                                    busy,
  output logic                                    done,
  output logic signed [asn1t_pkg::SEC_W-1:0]      epoch_seconds,
  output logic                                    bad
);
  import asn1t_pkg::*;

  logic [7:0]            store [STORE_DEPTH];
  logic [7:0]            rdata;
  logic [3:0]            raddr;
  logic [4:0]            count;
  logic [4:0]            count_inc;
  logic                  pos4_digit;
  logic                  short_len;
  logic                  gen;
  logic [PC_W-1:0]       pc;
  logic [PC_W-1:0]       pc_next;
  ctrl_t                 cw;
  logic                  jump;
  logic                  accept;
  logic                  ok;
  logic [3:0]            tens;
  logic [6:0]            f_c, f_yy, f_mon, f_day, f_hour, f_min, f_sec;
  logic [SEC_W-1:0]      acc;
  logic                  rd_digit;
  logic [3:0]            dig;
  logic [6:0]            pair_val;
  logic [13:0]           year_w;
  logic [7:0]            cent_sh;
  logic [7:0]            cent_m1;
  logic [6:0]            yy_m1;
  logic [11:0]           leap_cnt;
  logic                  leap_adj;
  logic [19:0]           hms;
  logic signed [SEC_W-1:0] year_ext;
  logic signed [SEC_W-1:0] day_ext;
  logic                  bad_now;

  assign accept    = start && !busy;
  assign count_inc = (count < COUNT_MAX) ? count + 5'd1 : count;
  assign cw        = ucode_rom(pc);

  // input side
  always_ff @(posedge clk) begin
    if (accept && (count < 5'(STORE_DEPTH))) begin
      store[count[3:0]] <= character;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      pos4_digit <= 1'b0;
      short_len  <= 1'b0;
      gen        <= 1'b0;
    end else if (accept) begin
      if (count == POS_YEAR_LO) begin
        pos4_digit <= (character inside {[ASCII_ZERO:ASCII_NINE]});
      end
      if (last_char) begin
        count     <= '0;
        short_len <= (count_inc < MIN_LEN);
        gen       <= (count_inc >= GEN_LEN) &&
                     ((count == POS_YEAR_LO) ?
                      (character inside {[ASCII_ZERO:ASCII_NINE]}) : pos4_digit);
      end else begin
        count <= count_inc;
      end
    end
  end

  // store read port
  assign raddr = cw.rd_rel ? ((gen ? BASE_GEN : BASE_UTC) + cw.rd_off) : cw.rd_off;

  always_ff @(posedge clk) begin
    rdata <= store[raddr];
  end

  // sequencer
  always_comb begin
    case (cw.cond)
      COND_SHORT:  jump = short_len;
      COND_UTC:    jump = !gen;
      COND_ALWAYS: jump = 1'b1;
      default:     jump = 1'b0;
    endcase
    pc_next = jump ? cw.target : pc + 5'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pc   <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (!busy) begin
        if (accept && last_char) begin
          busy <= 1'b1;
          pc   <= '0;
        end
      end else if (cw.op == OP_FIN) begin
        busy <= 1'b0;
        done <= 1'b1;
      end else begin
        pc <= pc_next;
      end
    end
  end

  // datapath
  assign rd_digit = rdata inside {[ASCII_ZERO:ASCII_NINE]};
  assign dig      = 4'(rdata - ASCII_ZERO);
  assign pair_val = 7'({3'b000, tens} * 7'd10) + {3'b000, dig};
  assign year_w   = 14'({7'd0, f_c} * 14'd100) + {7'd0, f_yy};
  assign cent_sh  = {1'b0, f_c} + 8'd4;
  assign cent_m1  = cent_sh - 8'd1;
  assign yy_m1    = f_yy - 7'd1;

  always_comb begin
    if (f_yy == 7'd0) begin
      leap_cnt = 12'({4'd0, cent_sh} * 12'd24) + {6'd0, cent_m1[7:2]};
      leap_adj = (f_mon > 7'd2) && (f_c[1:0] == 2'b00);
    end else begin
      leap_cnt = 12'({4'd0, cent_sh} * 12'd24) + {7'd0, yy_m1[6:2]} + {6'd0, cent_sh[7:2]};
      leap_adj = (f_mon > 7'd2) && (f_yy[1:0] == 2'b00);
    end
  end

  assign hms = 20'({13'd0, f_hour} * 20'd3600) + 20'({13'd0, f_min} * 20'd60)
             + {13'd0, f_sec};
  assign year_ext = SEC_W'($signed(acc[15:0]));
  assign day_ext  = SEC_W'($signed(acc[23:0]));
  assign bad_now  = short_len || !ok || (f_mon == 7'd0) || (f_mon > 7'd12);

  always_ff @(posedge clk) begin
    if (busy) begin
      case (cw.op)
        OP_HI:      tens   <= dig;
        OP_LO_C:    f_c    <= pair_val;
        OP_LO_YY:   f_yy   <= pair_val;
        OP_LO_MON:  f_mon  <= pair_val;
        OP_LO_DAY:  f_day  <= pair_val;
        OP_LO_HOUR: f_hour <= pair_val;
        OP_LO_MIN:  f_min  <= pair_val;
        OP_LO_SEC:  f_sec  <= pair_val;
        OP_CENT:    f_c    <= (f_yy < YY_PIVOT) ? CENT_20 : CENT_19;
        OP_YEAR:    acc    <= {25'd0, year_w} - EPOCH_YEAR;
        OP_MUL365:  acc    <= SEC_W'(year_ext * $signed(DAYS_YEAR));
        OP_LEAP:    acc    <= acc + {27'd0, leap_cnt} - LEAP_BASE;
        OP_MONTH:   acc    <= acc + {30'd0, month_offset(f_mon)} + {38'd0, leap_adj}
                              + {32'd0, f_day} - 39'd1;
        OP_MULDAY:  acc    <= SEC_W'(day_ext * $signed(SECS_DAY));
        OP_HMS:     acc    <= acc + {19'd0, hms};
        OP_FIN: begin
          bad           <= bad_now;
          epoch_seconds <= bad_now ? '0 : $signed(acc);
        end
        default: ;
      endcase
    end
  end

  // digit check flag
  always_ff @(posedge clk) begin
    if (rst) begin
      ok <= 1'b1;
    end else if (!busy) begin
      ok <= 1'b1;
    end else if ((cw.op inside {OP_HI, OP_LO_C, OP_LO_YY, OP_LO_MON, OP_LO_DAY,
                                OP_LO_HOUR, OP_LO_MIN, OP_LO_SEC}) && !rd_digit) begin
      ok <= 1'b0;
    end
  end

  `A1T_ASSERT_NOW(a_done_idle, clk, rst, done, !busy, "result word while sequencer busy")
  `A1T_ASSERT_NOW(a_bad_zero, clk, rst, done && bad, epoch_seconds == '0, "bad word not zero")
  `A1T_ASSERT_NEXT(a_last_starts, clk, rst, start && !busy && last_char, busy && (pc == '0),
                   "last character did not start sequencer")
  `A1T_ASSERT_NEXT(a_fin_done, clk, rst, busy && (cw.op == OP_FIN), done && !busy,
                   "finish step gave no result word")

endmodule
`default_nettype wire
